// ===== rtl/adaptive_position_smoother_defines.svh =====
// Assertion macros shared by the smoother RTL.
`ifndef ADAPTIVE_POSITION_SMOOTHER_DEFINES_SVH
`define ADAPTIVE_POSITION_SMOOTHER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define APS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define APS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aps_pkg.sv =====
// Types, constants and register codes of the adaptive position smoother.
package aps_pkg;

  localparam int NUM_LANES = 8;
  localparam int NUM_PAIRS = NUM_LANES / 2;
  localparam int RES_W     = 16;
  localparam int SQ_W      = 2 * RES_W - 1;
  localparam int PAIR_W    = SQ_W + 1;
  localparam int SUM_W     = SQ_W + $clog2(NUM_LANES);
  localparam int POS_W     = 32;
  localparam int DIFF_W    = POS_W + 1;
  localparam int THR_W     = 34;
  localparam int CODE_W    = 3;
  localparam int CNT_W     = 4;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 64;
  localparam int PROD_W    = 2 * POS_W;

  // floor(u / 5) = (u * RECIP5) >> RECIP5_SHIFT for every 32-bit u
  localparam logic [POS_W-1:0] RECIP5       = 32'hCCCC_CCCD;
  localparam int               RECIP5_SHIFT = 34;
  localparam int               QUOT_W       = PROD_W - RECIP5_SHIFT;
  // -h + 4 written as ~h + 5
  localparam logic [POS_W-1:0] NEG_ROUND_BIAS = 32'd5;

  localparam logic [CNT_W-1:0] THREE_STATIONS = 4'd3;

  localparam logic [THR_W-1:0] RST_THR_VERY_GOOD = 34'd655360;
  localparam logic [THR_W-1:0] RST_THR_GOOD      = 34'd3276800;
  localparam logic [THR_W-1:0] RST_THR_AVERAGE   = 34'd6553600;

  typedef enum logic [CODE_W-1:0] {
    WC_K2  = 3'd0,
    WC_K4  = 3'd1,
    WC_K8  = 3'd2,
    WC_K16 = 3'd3,
    WC_K10 = 3'd4
  } weight_code_t;

  typedef enum logic [1:0] {
    REG_THR_VERY_GOOD = 2'd0,
    REG_THR_GOOD      = 2'd1,
    REG_THR_AVERAGE   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    SM_IDLE,
    SM_PREP,
    SM_MUL,
    SM_ADD
  } sm_state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position_x;
    logic signed [POS_W-1:0] position_y;
    logic                    first_fix;
    logic [CNT_W-1:0]        num_stations;
    logic signed [RES_W-1:0] residual_0;
    logic signed [RES_W-1:0] residual_1;
    logic signed [RES_W-1:0] residual_2;
    logic signed [RES_W-1:0] residual_3;
    logic signed [RES_W-1:0] residual_4;
    logic signed [RES_W-1:0] residual_5;
    logic signed [RES_W-1:0] residual_6;
    logic signed [RES_W-1:0] residual_7;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] filtered_x_out;
    logic signed [POS_W-1:0] filtered_y_out;
    logic [CODE_W-1:0]       weight_code;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             first_fix;
    logic             three;
  } fix_meta_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    fix_meta_t        meta;
  } sum_item_t;

  typedef struct packed {
    logic [THR_W-1:0] very_good;
    logic [THR_W-1:0] good;
    logic [THR_W-1:0] average;
  } thr_set_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic mul;
    logic commit;
  } axis_ctl_t;

endpackage

// ===== rtl/aps_lane.sv =====
// One residual lane: masked square of a station residual, registered.
module aps_lane (
  input  logic                              clk,
  input  logic                              load,
  input  logic signed [aps_pkg::RES_W-1:0]  residual,
  input  logic                              used,
  output logic [aps_pkg::SQ_W-1:0]          sq
);

  logic signed [2*aps_pkg::RES_W-1:0] sq_full;

  assign sq_full = residual * residual;

  always_ff @(posedge clk) begin
    if (load) begin
      // drop stations past the count
      sq <= used ? sq_full[aps_pkg::SQ_W-1:0] : '0;
    end
  end

endmodule

// ===== rtl/aps_merge.sv =====
// Two-stage registered adder tree that merges the lane squares into one sum.
module aps_merge (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            in_valid,
  input  logic [aps_pkg::NUM_LANES-1:0][aps_pkg::SQ_W-1:0] sq,
  input  aps_pkg::fix_meta_t                              meta,
  input  logic                                            take,
  output logic                                            ready,
  output logic                                            out_valid,
  output aps_pkg::sum_item_t                              out_item
);

  logic [aps_pkg::NUM_PAIRS-1:0][aps_pkg::PAIR_W-1:0] pair;
  aps_pkg::fix_meta_t                                 meta1;
  logic                                               v1;
  logic                                               en1;
  logic                                               en2;
  logic [aps_pkg::SUM_W-1:0]                          total;

  assign en2   = !out_valid || take;
  assign en1   = !v1 || en2;
  assign ready = en1;

  always_comb begin
    total = '0;
    for (int p = 0; p < aps_pkg::NUM_PAIRS; p++) begin
      total = total + aps_pkg::SUM_W'(pair[p]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      for (int p = 0; p < aps_pkg::NUM_PAIRS; p++) begin
        pair[p] <= {1'b0, sq[2*p]} + {1'b0, sq[2*p+1]};
      end
      meta1 <= meta;
    end
    if (en2 && v1) begin
      out_item.sum  <= total;
      out_item.meta <= meta1;
    end
  end

endmodule

// ===== rtl/aps_axis.sv =====
// One coordinate of the smoother: stored position and its update datapath.
module aps_axis (
  input  logic                          clk,
  input  logic                          rst,
  input  aps_pkg::axis_ctl_t            ctl,
  input  logic [aps_pkg::POS_W-1:0]     fix,
  input  logic                          first_fix,
  input  aps_pkg::weight_code_t         code,
  output logic [aps_pkg::POS_W-1:0]     filtered
);

  logic [aps_pkg::POS_W-1:0]  fix_q;
  logic [aps_pkg::DIFF_W-1:0] diff;
  logic [aps_pkg::POS_W-1:0]  step;
  logic [aps_pkg::POS_W-1:0]  mag;
  logic                       neg;
  logic [aps_pkg::PROD_W-1:0] prod;

  logic [aps_pkg::DIFF_W-1:0] shifted;
  logic [aps_pkg::POS_W-1:0]  half;
  logic [aps_pkg::QUOT_W-1:0] quot;
  logic [aps_pkg::POS_W-1:0]  q_ext;
  logic [aps_pkg::POS_W-1:0]  op;
  logic [aps_pkg::POS_W-1:0]  smooth;

  always_comb begin
    case (code)
      aps_pkg::WC_K2:  shifted = $unsigned($signed(diff) >>> 1);
      aps_pkg::WC_K4:  shifted = $unsigned($signed(diff) >>> 2);
      aps_pkg::WC_K8:  shifted = $unsigned($signed(diff) >>> 3);
      aps_pkg::WC_K16: shifted = $unsigned($signed(diff) >>> 4);
      default:         shifted = '0;
    endcase
  end

  // floor(d/10) = floor(floor(d/2)/5); negative halves go through -floor((4-h)/5)
  assign half  = diff[aps_pkg::DIFF_W-1:1];
  assign quot  = prod[aps_pkg::PROD_W-1:aps_pkg::RECIP5_SHIFT];
  assign q_ext = aps_pkg::POS_W'(quot);

  always_comb begin
    if (code == aps_pkg::WC_K10) begin
      op = neg ? ~q_ext : q_ext;
    end else begin
      op = step;
    end
    smooth = filtered + op + aps_pkg::POS_W'(neg && (code == aps_pkg::WC_K10));
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      diff  <= {fix[aps_pkg::POS_W-1], fix} - {filtered[aps_pkg::POS_W-1], filtered};
      fix_q <= fix;
    end
    if (ctl.prep) begin
      step <= shifted[aps_pkg::POS_W-1:0];
      neg  <= half[aps_pkg::POS_W-1];
      mag  <= half[aps_pkg::POS_W-1] ? (~half + aps_pkg::NEG_ROUND_BIAS) : half;
    end
    if (ctl.mul) begin
      prod <= mag * aps_pkg::RECIP5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered <= '0;
    end else if (ctl.commit) begin
      filtered <= first_fix ? fix_q : smooth;
    end
  end

endmodule

// ===== rtl/aps_smoother.sv =====
// Weight selection, sequencing of the x/y update and the result register.
module aps_smoother (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  aps_pkg::sum_item_t   in_item,
  input  aps_pkg::thr_set_t    thr,
  input  logic                 out_stall,
  output logic                 ready,
  output logic                 out_valid,
  output aps_pkg::out_item_t   out_item
);

  aps_pkg::sm_state_t    state;
  aps_pkg::sm_state_t    state_next;
  aps_pkg::weight_code_t code;
  aps_pkg::weight_code_t code_next;
  aps_pkg::weight_code_t out_code;
  aps_pkg::axis_ctl_t    ctl;
  logic                  first_q;
  logic                  out_free;
  logic [aps_pkg::POS_W-1:0] fx;
  logic [aps_pkg::POS_W-1:0] fy;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (in_item.meta.three) begin
      code_next = aps_pkg::WC_K10;
    end else if (in_item.sum < thr.very_good) begin
      code_next = aps_pkg::WC_K2;
    end else if (in_item.sum < thr.good) begin
      code_next = aps_pkg::WC_K4;
    end else if (in_item.sum < thr.average) begin
      code_next = aps_pkg::WC_K8;
    end else begin
      code_next = aps_pkg::WC_K16;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      aps_pkg::SM_IDLE: if (in_valid) state_next = aps_pkg::SM_PREP;
      aps_pkg::SM_PREP: state_next = aps_pkg::SM_MUL;
      aps_pkg::SM_MUL:  state_next = aps_pkg::SM_ADD;
      aps_pkg::SM_ADD:  if (out_free) state_next = aps_pkg::SM_IDLE;
      default:          state_next = aps_pkg::SM_IDLE;
    endcase
  end

  always_comb begin
    ready       = 1'b0;
    ctl         = '0;
    case (state)
      aps_pkg::SM_IDLE: begin
        ready       = 1'b1;
        ctl.capture = in_valid;
      end
      aps_pkg::SM_PREP: ctl.prep = 1'b1;
      aps_pkg::SM_MUL:  ctl.mul = 1'b1;
      aps_pkg::SM_ADD:  ctl.commit = out_free;
      default:          ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= aps_pkg::SM_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      code    <= code_next;
      first_q <= in_item.meta.first_fix;
    end
    if (ctl.commit) begin
      out_code <= code;
    end
  end

  aps_axis u_axis_x (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .fix       (in_item.meta.pos_x),
    .first_fix (first_q),
    .code      (code),
    .filtered  (fx)
  );

  aps_axis u_axis_y (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .fix       (in_item.meta.pos_y),
    .first_fix (first_q),
    .code      (code),
    .filtered  (fy)
  );

  // the stored position only moves on commit, so it doubles as the result payload
  always_comb begin
    out_item.filtered_x_out = fx;
    out_item.filtered_y_out = fy;
    out_item.weight_code    = out_code;
  end

endmodule

// ===== rtl/adaptive_position_smoother.sv =====
// Top level of the adaptive position smoother: lanes, merge tree, smoother, registers.
//
//   channel   direction  handshake                      payload
//   fix       in         fix_valid / fix_stall          aps_pkg::in_item_t
//   result    out        result_valid / result_stall    aps_pkg::out_item_t
//   config    in         psel/penable/pwrite, pready=1  paddr[4:0], pwdata/prdata 64b
//
// The smoother takes no new fix until the last one has gone round the loop through the
// stored position: capture difference, scale/prepare, reciprocal multiply, add.
// result_valid rises once a fix has passed the lane stage, both merge stages and these steps.
// Lane stage and merge tree hold three more fixes while a result waits.
// Reset is synchronous: stored position to zero, thresholds to 10.0, 50.0, 100.0 (Q16.16).
// A result stall holds the smoother at its add step and backs the pipe up to fix_stall.
`include "adaptive_position_smoother_defines.svh"

module adaptive_position_smoother (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fix_valid,
  output logic                          fix_stall,
  input  aps_pkg::in_item_t             fix,
  output logic                          result_valid,
  input  logic                          result_stall,
  output aps_pkg::out_item_t            result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aps_pkg::ADDR_W-1:0]    paddr,
  input  logic [aps_pkg::DATA_W-1:0]    pwdata,
  output logic [aps_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  // threshold registers
  aps_pkg::thr_set_t  thr;
  aps_pkg::reg_idx_t  reg_idx;

  // lane stage
  logic                                              s1_valid;
  logic                                              s1_en;
  logic                                              accept;
  aps_pkg::fix_meta_t                                s1_meta;
  logic [aps_pkg::NUM_LANES-1:0][aps_pkg::RES_W-1:0] res;
  logic [aps_pkg::NUM_LANES-1:0][aps_pkg::SQ_W-1:0]  sq;

  // merge and smoother handshake
  logic               mg_ready;
  logic               mg_valid;
  aps_pkg::sum_item_t mg_item;
  logic               sm_ready;

  // ---------------------------------------------------------------------
  // Configuration port: writes land on the access cycle, reads are direct.
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = aps_pkg::reg_idx_t'(paddr[aps_pkg::ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.very_good <= aps_pkg::RST_THR_VERY_GOOD;
      thr.good      <= aps_pkg::RST_THR_GOOD;
      thr.average   <= aps_pkg::RST_THR_AVERAGE;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        aps_pkg::REG_THR_VERY_GOOD: thr.very_good <= pwdata[aps_pkg::THR_W-1:0];
        aps_pkg::REG_THR_GOOD:      thr.good      <= pwdata[aps_pkg::THR_W-1:0];
        aps_pkg::REG_THR_AVERAGE:   thr.average   <= pwdata[aps_pkg::THR_W-1:0];
        default:                    ; // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      aps_pkg::REG_THR_VERY_GOOD: prdata = aps_pkg::DATA_W'(thr.very_good);
      aps_pkg::REG_THR_GOOD:      prdata = aps_pkg::DATA_W'(thr.good);
      aps_pkg::REG_THR_AVERAGE:   prdata = aps_pkg::DATA_W'(thr.average);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Lane stage: each lane squares one residual, masked by the station count.
  // Advance whenever the stage is empty or the merge tree takes its item.
  // ---------------------------------------------------------------------
  assign s1_en     = !s1_valid || mg_ready;
  assign fix_stall = !s1_en;
  assign accept    = fix_valid && s1_en;

  assign res[0] = fix.residual_0;
  assign res[1] = fix.residual_1;
  assign res[2] = fix.residual_2;
  assign res[3] = fix.residual_3;
  assign res[4] = fix.residual_4;
  assign res[5] = fix.residual_5;
  assign res[6] = fix.residual_6;
  assign res[7] = fix.residual_7;

  for (genvar i = 0; i < aps_pkg::NUM_LANES; i++) begin : g_lane
    // lanes at or beyond the count contribute nothing; counts above the lane
    // total simply enable every lane
    aps_lane u_lane (
      .clk      (clk),
      .load     (accept),
      .residual (res[i]),
      .used     (fix.num_stations > aps_pkg::CNT_W'(i)),
      .sq       (sq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= fix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta.pos_x     <= fix.position_x;
      s1_meta.pos_y     <= fix.position_y;
      s1_meta.first_fix <= fix.first_fix;
      s1_meta.three     <= (fix.num_stations == aps_pkg::THREE_STATIONS);
    end
  end

  // ---------------------------------------------------------------------
  // Merge the lane squares into the Q16.16 residual sum.
  // ---------------------------------------------------------------------
  aps_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .sq        (sq),
    .meta      (s1_meta),
    .take      (mg_valid && sm_ready),
    .ready     (mg_ready),
    .out_valid (mg_valid),
    .out_item  (mg_item)
  );

  // ---------------------------------------------------------------------
  // Pick the weight, update the stored position, hold the result.
  // ---------------------------------------------------------------------
  aps_smoother u_smoother (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mg_valid),
    .in_item   (mg_item),
    .thr       (thr),
    .out_stall (result_stall),
    .ready     (sm_ready),
    .out_valid (result_valid),
    .out_item  (result)
  );

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // a stalled fix channel means the lane stage is holding an item
  `APS_ASSERT_NOW(a_stall_needs_full_lane, clk, rst, fix_stall, s1_valid, "fix stall with empty lane stage")
  // once the smoother takes a sum it is busy for the next cycle
  `APS_ASSERT_NEXT(a_take_makes_busy, clk, rst, mg_valid && sm_ready, !sm_ready, "smoother not busy after take")
  // a result only appears from the add step, never straight out of idle
  `APS_ASSERT_NEXT(a_no_result_from_idle, clk, rst, sm_ready, !$rose(result_valid), "result raised from idle")

endmodule
